/* hw/rtl/refcounted_page_allocator_assert.svh */
// Assertion helpers for the page allocator, clocked on clk with rst_n as
// the disable condition.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define RPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication.
`define RPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

/* hw/rtl/rpa_pkg.sv */
`timescale 1ns / 1ps

package rpa_pkg;

    localparam int NUM_PAGES_DEF = 32768;
    localparam int REF_WIDTH_DEF = 16;

    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 32;
    localparam int PN_W       = ADDR_W - PAGE_SHIFT;
    localparam int FP_W       = 15;
    localparam int AADDR_W    = 27;
    localparam int REFO_W     = 16;
    localparam int STATUS_W   = 3;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLONE = 2'd2,
        OP_INIT  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_ADDR      = 3'd1,
        ST_FREE_UNALLOC  = 3'd2,
        ST_CLONE_UNALLOC = 3'd3,
        ST_OOM           = 3'd4,
        ST_OVERFLOW      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INIT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic init_step;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic init_empty;
        logic init_last;
    } sts_t;

endpackage

/* hw/rtl/refcounted_page_allocator.sv */
// Channel   Handshake              Payload
// request   req_valid/req_ready    opcode, page_addr
// response  rsp_valid/rsp_ready    status, alloc_addr, ref_after
// config    cfg_we                 cfg_wdata (first usable page)
//
// Alloc, free and clone: the accept cycle reads both tables through their registered
// read port; the execute state, held while a result waits, writes back and updates
// the head. Init sweeps one page per cycle through the single write port of each
// table, the last page held while a result waits; none when first_page >= NUM_PAGES.
// Reset empties the free list at once; the tables are not cleared.
// One result register parts the channels: the next item is accepted while a
// result waits, and its completion holds until that result is taken.
`timescale 1ns / 1ps

module refcounted_page_allocator
#(
    parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF,
    parameter int REF_WIDTH = rpa_pkg::REF_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [1:0]                      opcode,
    input  logic [rpa_pkg::ADDR_W-1:0]      page_addr,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [rpa_pkg::STATUS_W-1:0]    status,
    output logic [rpa_pkg::AADDR_W-1:0]     alloc_addr,
    output logic [rpa_pkg::REFO_W-1:0]      ref_after,
    input  logic                            cfg_we,
    input  logic [rpa_pkg::FP_W-1:0]        cfg_wdata
);

`include "refcounted_page_allocator_assert.svh"

    rpa_pkg::cmd_t    cmd;
    rpa_pkg::sts_t    sts;
    rpa_pkg::status_t status_enum;

    // Sequencer: accept, execute, init sweep, result hand-off
    rpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Tables, free-list head, address check and result register
    rpa_datapath
    #(
        .NUM_PAGES (NUM_PAGES),
        .REF_WIDTH (REF_WIDTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (opcode),
        .page_addr  (page_addr),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .sts        (sts),
        .status     (status_enum),
        .alloc_addr (alloc_addr),
        .ref_after  (ref_after)
    );

    assign status = status_enum;

    // An accepted item is never executed in the same cycle
    `RPA_ASSERT_NOW(a_no_exec_on_accept, req_valid && req_ready, !cmd.exec && !cmd.init_step)
    // Execution only when the result register is free
    `RPA_ASSERT_NOW(a_exec_slot_free, cmd.exec, !rsp_valid || rsp_ready)
    // A table operation always produces its result right away
    `RPA_ASSERT_NEXT(a_exec_result, cmd.exec && sts.op != rpa_pkg::OP_INIT, rsp_valid)
    // The last page of the sweep closes the init item
    `RPA_ASSERT_NEXT(a_init_result, cmd.init_step && sts.init_last, rsp_valid)

endmodule

/* hw/rtl/rpa_ctrl.sv */
`timescale 1ns / 1ps

module rpa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  rpa_pkg::sts_t sts,
    output rpa_pkg::cmd_t cmd
);

    rpa_pkg::state_t state_reg;
    rpa_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        slot_free  = !out_valid_reg || rsp_ready;
        case (state_reg)
            rpa_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = rpa_pkg::S_EXEC;
                end
            end
            rpa_pkg::S_EXEC:
            begin
                // hold until the result register can take the item
                if (slot_free)
                begin
                    cmd.exec = 1'b1;
                    if (sts.op == rpa_pkg::OP_INIT && !sts.init_empty)
                    begin
                        state_next = rpa_pkg::S_INIT;
                    end
                    else
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = rpa_pkg::S_IDLE;
                    end
                end
            end
            rpa_pkg::S_INIT:
            begin
                if (!sts.init_last || slot_free)
                begin
                    cmd.init_step = 1'b1;
                    if (sts.init_last)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = rpa_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rpa_pkg::S_IDLE;
            end
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

endmodule

/* hw/rtl/rpa_datapath.sv */
`timescale 1ns / 1ps

module rpa_datapath
#(
    parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF,
    parameter int REF_WIDTH = rpa_pkg::REF_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    opcode,
    input  logic [rpa_pkg::ADDR_W-1:0]    page_addr,
    input  logic                          cfg_we,
    input  logic [rpa_pkg::FP_W-1:0]      cfg_wdata,
    input  rpa_pkg::cmd_t                 cmd,
    output rpa_pkg::sts_t                 sts,
    output rpa_pkg::status_t              status,
    output logic [rpa_pkg::AADDR_W-1:0]   alloc_addr,
    output logic [rpa_pkg::REFO_W-1:0]    ref_after
);

    localparam int PG_W    = $clog2(NUM_PAGES);
    localparam int REFO_W  = rpa_pkg::REFO_W;
    localparam int AADDR_W = rpa_pkg::AADDR_W;
    localparam int PS      = rpa_pkg::PAGE_SHIFT;
    localparam int PN_W    = rpa_pkg::PN_W;

    // link store: {valid, next page}; count store
    logic [PG_W:0]          link_mem [NUM_PAGES];
    logic [REF_WIDTH-1:0]   ref_mem  [NUM_PAGES];

    logic [rpa_pkg::FP_W-1:0] first_page_reg;
    rpa_pkg::op_t             op_reg;
    logic [PG_W-1:0]          pg_reg;
    logic                     bad_reg;
    logic [PG_W-1:0]          head_reg;
    logic [PG_W-1:0]          head_next;
    logic                     head_valid_reg;
    logic                     head_valid_next;
    logic [PG_W-1:0]          cnt_reg;
    logic [PG_W-1:0]          cnt_next;
    logic [PG_W:0]            rd_link_reg;
    logic [REF_WIDTH-1:0]     rd_ref_reg;

    logic [PN_W-1:0]          in_pn;
    logic [PG_W-1:0]          rd_idx;
    logic                     in_bad;

    logic                     lk_we;
    logic [PG_W-1:0]          lk_wa;
    logic [PG_W:0]            lk_wd;
    logic                     rf_we;
    logic [PG_W-1:0]          rf_wa;
    logic [REF_WIDTH-1:0]     rf_wd;

    rpa_pkg::status_t         res_status;
    logic [31:0]              res_aaddr_w;
    logic [REF_WIDTH-1:0]     res_ref;

    assign in_pn  = page_addr[rpa_pkg::ADDR_W-1:PS];
    assign in_bad = (page_addr[PS-1:0] != '0)
                 || (in_pn < PN_W'(first_page_reg))
                 || (32'(in_pn) >= 32'(NUM_PAGES));
    assign rd_idx = (opcode == rpa_pkg::OP_ALLOC) ? head_reg : PG_W'(in_pn);

    assign sts.op         = op_reg;
    assign sts.init_empty = 32'(first_page_reg) >= 32'(NUM_PAGES);
    assign sts.init_last  = cnt_reg == PG_W'(NUM_PAGES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= '0;
            head_valid_reg <= 1'b0;
            head_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                first_page_reg <= cfg_wdata;
            head_valid_reg <= head_valid_next;
            head_reg       <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= rpa_pkg::op_t'(opcode);
            pg_reg      <= PG_W'(in_pn);
            bad_reg     <= in_bad;
            rd_link_reg <= link_mem[rd_idx];
            rd_ref_reg  <= ref_mem[rd_idx];
        end
        cnt_reg <= cnt_next;
        if (lk_we)
            link_mem[lk_wa] <= lk_wd;
        if (rf_we)
            ref_mem[rf_wa] <= rf_wd;
        if (cmd.load_out)
        begin
            status     <= res_status;
            alloc_addr <= res_aaddr_w[AADDR_W-1:0];
            ref_after  <= REFO_W'(32'(res_ref));
        end
    end

    always_comb
    begin
        lk_we           = 1'b0;
        lk_wa           = pg_reg;
        lk_wd           = {head_valid_reg, head_reg};
        rf_we           = 1'b0;
        rf_wa           = pg_reg;
        rf_wd           = '0;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        cnt_next        = cnt_reg;
        res_status      = rpa_pkg::ST_OK;
        res_aaddr_w     = '0;
        res_ref         = '0;

        case (op_reg)
            rpa_pkg::OP_ALLOC:
            begin
                if (head_valid_reg)
                begin
                    rf_we       = cmd.exec;
                    rf_wa       = head_reg;
                    rf_wd       = REF_WIDTH'(1);
                    res_aaddr_w = 32'(head_reg) << PS;
                    res_ref     = REF_WIDTH'(1);
                    if (cmd.exec)
                    begin
                        head_next       = rd_link_reg[PG_W-1:0];
                        head_valid_next = rd_link_reg[PG_W];
                    end
                end
                else
                begin
                    res_status = rpa_pkg::ST_OOM;
                end
            end
            rpa_pkg::OP_FREE:
            begin
                if (bad_reg)
                    res_status = rpa_pkg::ST_BAD_ADDR;
                else if (rd_ref_reg == '0)
                    res_status = rpa_pkg::ST_FREE_UNALLOC;
                else if (rd_ref_reg > REF_WIDTH'(1))
                begin
                    rf_we   = cmd.exec;
                    rf_wd   = rd_ref_reg - REF_WIDTH'(1);
                    res_ref = rd_ref_reg - REF_WIDTH'(1);
                end
                else
                begin
                    // last reference: push the page back on the list
                    rf_we = cmd.exec;
                    lk_we = cmd.exec;
                    if (cmd.exec)
                    begin
                        head_next       = pg_reg;
                        head_valid_next = 1'b1;
                    end
                end
            end
            rpa_pkg::OP_CLONE:
            begin
                if (bad_reg)
                    res_status = rpa_pkg::ST_BAD_ADDR;
                else if (rd_ref_reg == '0)
                    res_status = rpa_pkg::ST_CLONE_UNALLOC;
                else if (rd_ref_reg == '1)
                begin
                    res_status = rpa_pkg::ST_OVERFLOW;
                    res_ref    = rd_ref_reg;
                end
                else
                begin
                    rf_we   = cmd.exec;
                    rf_wd   = rd_ref_reg + REF_WIDTH'(1);
                    res_ref = rd_ref_reg + REF_WIDTH'(1);
                end
            end
            rpa_pkg::OP_INIT:
            begin
                if (cmd.exec)
                begin
                    head_next       = '0;
                    head_valid_next = 1'b0;
                    cnt_next        = PG_W'(32'(first_page_reg));
                end
            end
            default:
            begin
                res_status = rpa_pkg::ST_OK;
            end
        endcase

        // one page of the init sweep: zero its count and push it
        if (cmd.init_step)
        begin
            lk_we           = 1'b1;
            lk_wa           = cnt_reg;
            lk_wd           = {head_valid_reg, head_reg};
            rf_we           = 1'b1;
            rf_wa           = cnt_reg;
            rf_wd           = '0;
            head_next       = cnt_reg;
            head_valid_next = 1'b1;
            cnt_next        = cnt_reg + PG_W'(1);
        end
    end

endmodule

/* test/refcounted_page_allocator_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the page allocator. A ledger class mirrors the free
// list and the reference counts, works out the response to each accepted
// request and holds the responses still due. Plain tasks drive requests and
// the configuration register; the response side stalls at random.
module refcounted_page_allocator_test;
    import rpa_pkg::*;

    localparam int PAGES           = NUM_PAGES_DEF;
    localparam int PG_W            = $clog2(PAGES);
    localparam int COUNT_MAX       = (1 << REF_WIDTH_DEF) - 1;
    // A full init runs one page per cycle with nothing accepted; allow for
    // it several times over, plus the longest stalls on either side.
    localparam int QUIET_LIMIT     = 200000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int CLONE_RUN       = 24;

    typedef struct {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        status_t            status;
        logic [AADDR_W-1:0] alloc_addr;
        logic [REFO_W-1:0]  ref_after;
    } alloc_rsp_t;

    // Ledger of the allocator: free list, counts, and the responses due.
    class page_ledger;
        logic [REF_WIDTH_DEF-1:0] counts [PAGES];
        logic [PG_W-1:0]          links [PAGES];
        bit                       links_ok [PAGES];
        bit                       written [PAGES];
        logic [PG_W-1:0]          head;
        bit                       head_ok;
        logic [FP_W-1:0]          first_pg;
        int                       live_pages[$];
        alloc_rsp_t               due[$];
        int                       mismatches;

        function new();
            head       = '0;
            head_ok    = 1'b0;
            first_pg   = '0;
            mismatches = 0;
            foreach (written[p])
            begin
                counts[p]   = '0;
                links[p]    = '0;
                links_ok[p] = 1'b0;
                written[p]  = 1'b0;
            end
        endfunction

        function void set_first_page(logic [FP_W-1:0] fp);
            first_pg = fp;
        endfunction

        // Page number named by an address, or -1 when the address is bad.
        function int usable_page(logic [ADDR_W-1:0] a);
            int pg;
            pg = int'(a >> PAGE_SHIFT);
            if (a[PAGE_SHIFT-1:0] != '0 || pg < int'(first_pg) || pg >= PAGES)
                return -1;
            return pg;
        endfunction

        // Misalign any address whose page tables were never filled.
        function logic [ADDR_W-1:0] guard(logic [ADDR_W-1:0] a);
            int pg;
            pg = usable_page(a);
            if (pg >= 0 && !written[pg])
                return a | 1;
            return a;
        endfunction

        function int pick_live();
            if (live_pages.size() == 0)
                return -1;
            return live_pages[$urandom_range(0, live_pages.size() - 1)];
        endfunction

        function void push_free(int pg);
            links[pg]    = head;
            links_ok[pg] = head_ok;
            head         = pg[PG_W-1:0];
            head_ok      = 1'b1;
        endfunction

        function void drop_live(int pg);
            int idx;
            idx = -1;
            foreach (live_pages[i])
                if (live_pages[i] == pg && idx < 0)
                    idx = i;
            if (idx >= 0)
                live_pages.delete(idx);
        endfunction

        function void note_request(op_t op, logic [ADDR_W-1:0] a);
            alloc_rsp_t e;
            int         pg;
            int         kept[$];
            e.op         = op;
            e.addr       = a;
            e.status     = ST_OK;
            e.alloc_addr = '0;
            e.ref_after  = '0;
            case (op)
                OP_ALLOC:
                begin
                    if (head_ok)
                    begin
                        pg           = int'(head);
                        counts[pg]   = 1;
                        head         = links[pg];
                        head_ok      = links_ok[pg];
                        e.alloc_addr = AADDR_W'(pg) << PAGE_SHIFT;
                        e.ref_after  = 1;
                        live_pages.push_back(pg);
                    end
                    else
                        e.status = ST_OOM;
                end
                OP_FREE:
                begin
                    pg = usable_page(a);
                    if (pg < 0)
                        e.status = ST_BAD_ADDR;
                    else if (counts[pg] == 0)
                        e.status = ST_FREE_UNALLOC;
                    else if (counts[pg] > 1)
                    begin
                        counts[pg]  = counts[pg] - 1'b1;
                        e.ref_after = counts[pg];
                    end
                    else
                    begin
                        counts[pg] = 0;
                        push_free(pg);
                        drop_live(pg);
                    end
                end
                OP_CLONE:
                begin
                    pg = usable_page(a);
                    if (pg < 0)
                        e.status = ST_BAD_ADDR;
                    else if (counts[pg] == 0)
                        e.status = ST_CLONE_UNALLOC;
                    else if (counts[pg] == COUNT_MAX)
                    begin
                        e.status    = ST_OVERFLOW;
                        e.ref_after = counts[pg];
                    end
                    else
                    begin
                        counts[pg]  = counts[pg] + 1'b1;
                        e.ref_after = counts[pg];
                    end
                end
                default:
                begin
                    head_ok = 1'b0;
                    head    = '0;
                    for (int p = int'(first_pg); p < PAGES; p++)
                    begin
                        counts[p]  = 0;
                        written[p] = 1'b1;
                        push_free(p);
                    end
                    foreach (live_pages[i])
                        if (live_pages[i] < int'(first_pg))
                            kept.push_back(live_pages[i]);
                    live_pages = kept;
                end
            endcase
            due.push_back(e);
        endfunction

        function void check_response(logic [STATUS_W-1:0] st, logic [AADDR_W-1:0] aa,
                                     logic [REFO_W-1:0] ra);
            alloc_rsp_t e;
            if (due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with no request: status %0d alloc_addr 0x%07h %s %0d",
                             st, aa, "ref_after", ra);
                return;
            end
            e = due.pop_front();
            if (st !== e.status || aa !== e.alloc_addr || ra !== e.ref_after)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%s 0x%08h: expected status %0d alloc_addr 0x%07h %s %0d",
                             e.op.name(), e.addr, e.status, e.alloc_addr, "ref_after",
                             e.ref_after);
                    $display("    got status %0d alloc_addr 0x%07h ref_after %0d",
                             st, aa, ra);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    logic [1:0]          opcode;
    logic [ADDR_W-1:0]   page_addr;
    logic                rsp_valid;
    logic                rsp_ready;
    logic [STATUS_W-1:0] status;
    logic [AADDR_W-1:0]  alloc_addr;
    logic [REFO_W-1:0]   ref_after;
    logic                cfg_we;
    logic [FP_W-1:0]     cfg_wdata;

    page_ledger ledger = new();
    bit         no_idle = 1'b0;
    int         quiet = 0;

    refcounted_page_allocator i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .opcode     (opcode),
        .page_addr  (page_addr),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .alloc_addr (alloc_addr),
        .ref_after  (ref_after),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [ADDR_W-1:0] page_at(int pg);
        return ADDR_W'(pg) << PAGE_SHIFT;
    endfunction

    // Pick the next random request. Most of them alloc, free or clone pages
    // that are really in use; the rest hit free pages, bad addresses and,
    // while the usable range is small, a repeated init.
    function automatic void random_item(output op_t op, output logic [ADDR_W-1:0] a);
        int r;
        int pg;
        r  = $urandom_range(0, 99);
        op = OP_ALLOC;
        a  = $urandom;
        if (r >= 34 && r < 78)
        begin
            pg = ledger.pick_live();
            if (pg >= 0)
            begin
                op = (r < 58) ? OP_FREE : OP_CLONE;
                a  = page_at(pg);
            end
        end
        else if (r >= 78 && r < 88)
        begin
            pg = $urandom_range(int'(ledger.first_pg), PAGES - 1);
            op = r[0] ? OP_FREE : OP_CLONE;
            a  = ledger.guard(page_at(pg));
        end
        else if (r >= 88 && r < 98)
        begin
            op = r[0] ? OP_FREE : OP_CLONE;
            case (r % 3)
                0: a = $urandom;
                1: a = page_at($urandom_range(0, PAGES + 16));
                default: a = $urandom & 32'h07FF_FFFF;
            endcase
            a = ledger.guard(a);
        end
        else if (r >= 98 && int'(ledger.first_pg) >= PAGES - 512)
            op = OP_INIT;
    endfunction

    // Present one item and hold it until taken. Call at a falling edge;
    // returns at the falling edge after acceptance with valid still high,
    // so that a back-to-back item never drops it.
    task automatic send_request(input op_t op, input logic [ADDR_W-1:0] a);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        page_addr <= a;
        do
            @(posedge clk);
        while (!req_ready);
        ledger.note_request(op, a);
        @(negedge clk);
    endtask

    // Drop valid and wait until every response due has come back.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (ledger.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_first_page(input logic [FP_W-1:0] fp);
        cfg_we    <= 1'b1;
        cfg_wdata <= fp;
        @(negedge clk);
        cfg_we    <= 1'b0;
        ledger.set_first_page(fp);
    endtask

    // Response side: ready changes at the falling edge, stalls now and then.
    initial
    begin
        int stall;
        stall     = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0 && !no_idle)
            begin
                stall--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                stall = (no_idle || $urandom_range(0, 5) != 0) ? 0 : idle_len();
            end
        end
    end

    // Check each response taken, and watch for a stuck handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                ledger.check_response(status, alloc_addr, ref_after);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("** refcounted_page_allocator: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        op_t               op;
        logic [ADDR_W-1:0] a;
        logic [FP_W-1:0]   fp;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        opcode    = '0;
        page_addr = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Before any init the list is empty: alloc runs out of memory, and
        // only bad addresses may be freed or cloned.
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 32'h0000_0001);
        send_request(OP_CLONE, 32'hFFFF_F000);

        // Eight usable pages: drain the list, then walk one page through
        // clone, free to zero, and free and clone once unallocated.
        wait_idle();
        write_first_page(FP_W'(PAGES - 8));
        send_request(OP_INIT, 32'hFFFF_FFFF);
        repeat (9) send_request(OP_ALLOC, $urandom);
        send_request(OP_CLONE, page_at(PAGES - 1));
        send_request(OP_FREE, page_at(PAGES - 1));
        send_request(OP_FREE, page_at(PAGES - 1));
        send_request(OP_FREE, page_at(PAGES - 1));
        send_request(OP_CLONE, page_at(PAGES - 1));
        // Bad addresses: below the first page, past the top, misaligned.
        send_request(OP_FREE, page_at(PAGES - 9));
        send_request(OP_CLONE, page_at(PAGES));
        send_request(OP_FREE, page_at(PAGES - 1) | 32'h800);
        send_request(OP_ALLOC, '0);

        // Re-init over the top half only; the counts below must survive,
        // which shows once the first page is lowered again.
        wait_idle();
        write_first_page(FP_W'(PAGES - 4));
        send_request(OP_INIT, '0);
        wait_idle();
        write_first_page(FP_W'(PAGES - 8));
        send_request(OP_CLONE, page_at(PAGES - 8));
        send_request(OP_FREE, page_at(PAGES - 5));
        send_request(OP_ALLOC, '0);
        send_request(OP_INIT, '0);

        // One usable page, cloned two dozen times in a row.
        // Run flat out with no gaps on either side.
        wait_idle();
        write_first_page(FP_W'(PAGES - 1));
        send_request(OP_INIT, $urandom);
        send_request(OP_ALLOC, '0);
        no_idle = 1'b1;
        repeat (CLONE_RUN) send_request(OP_CLONE, page_at(PAGES - 1));
        no_idle = 1'b0;
        send_request(OP_FREE, page_at(PAGES - 1));
        send_request(OP_CLONE, page_at(PAGES - 1));
        send_request(OP_CLONE, page_at(PAGES - 1));

        // Random phases: the whole memory once, a lowered first page with no
        // init once, otherwise a small usable range so inits stay short.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            if (ph == 0)
                fp = '0;
            else if (ph == PHASES / 2)
                fp = FP_W'($urandom_range(0, PAGES - 1));
            else
                fp = FP_W'(PAGES - $urandom_range(1, 300));
            write_first_page(fp);
            if (ph != PHASES / 2)
                send_request(OP_INIT, $urandom);
            repeat (ITEMS_PER_PHASE)
            begin
                random_item(op, a);
                send_request(op, a);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.due.size() == 0)
            $display("** refcounted_page_allocator: PASSED **");
        else
            $display("** refcounted_page_allocator: FAILED **");
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_ctrl.sv
hw/rtl/rpa_datapath.sv
hw/rtl/refcounted_page_allocator.sv
test/refcounted_page_allocator_test.sv
